>>> src/sawbdc_pkg.sv
// ----------------------------------------------------------------------------
// sawbdc_pkg
// Shared types and command codes for the set-associative write-back cache.
// ----------------------------------------------------------------------------
package sawbdc_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [31:0] fill_data;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_data;
        logic        mem_write_valid;
        logic [31:0] mem_address;
        logic [31:0] mem_write_data;
        logic        fill_request;
        logic        last;
    } t_rsp;

endpackage

>>> src/sawbdc_if.sv
// ----------------------------------------------------------------------------
// sawbdc_if
// Valid/ready channel carrying one cache item.
// ----------------------------------------------------------------------------
interface sawbdc_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/set_assoc_write_back_data_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_write_back_data_cache
// Write-back, write-allocate set-associative cache with age-based replacement.
// ----------------------------------------------------------------------------
//   channel   dir  payload
//   i_req     in   cmd, address, write_data, fill_data
//   o_rsp     out  hit, read_data, mem_write_valid, mem_address,
//                  mem_write_data, fill_request, last
//
// hit: set metadata read, line word read, respond; refused access: set
// metadata read, respond. miss: set metadata read, a word read and a respond
// step per written-back word, then the fill request; each fill word is written
// as it is taken, and the last one is followed by a merge step when a write is
// merged. one item at a time, set by the single-port tag/meta and line
// memories. the output register holds a result until taken; no item is taken
// while a result waits and a stalled output stops the sequencer. reset clears
// valid, dirty and age bits with one pass over the sets before items are taken.
module set_assoc_write_back_data_cache #(
    parameter int SETS       = 256,
    parameter int WAYS       = 8,
    parameter int LINE_WORDS = 8,
    parameter int AGE_MAX    = 7
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sawbdc_if.sink   i_req,
    sawbdc_if.source o_rsp
);
    import sawbdc_pkg::*;

    localparam int OW = $clog2(LINE_WORDS);
    localparam int SW = $clog2(SETS);
    localparam int WW = $clog2(WAYS);
    localparam int TW = 30 - OW - SW;
    localparam int AW = $clog2(AGE_MAX + 1);
    localparam int LW = SW + WW + OW;

    typedef struct packed {
        logic          valid;
        logic          dirty;
        logic [AW-1:0] age;
        logic [TW-1:0] tag;
    } t_meta;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_WORD, S_WB, S_WBLAST, S_OUT, S_MERGE
    } t_state;

    t_meta       r_meta_mem [SETS][WAYS];
    logic [31:0] r_line_mem [SETS*WAYS*LINE_WORDS];

    t_meta         r_meta_q [WAYS];
    logic [31:0]   r_word_q;
    t_state        r_state;
    logic [SW-1:0] r_clr;
    logic [1:0]    r_cmd;
    logic [TW-1:0] r_tag;
    logic [SW-1:0] r_set;
    logic [OW-1:0] r_off;
    logic [31:0]   r_wdata;
    logic [WW-1:0] r_way;
    logic [OW-1:0] r_k;
    logic [TW-1:0] r_vtag;
    logic          r_busy;
    logic [OW-1:0] r_fidx;
    logic [SW-1:0] r_fset;
    logic [WW-1:0] r_fway;
    logic          r_pend;
    logic [OW-1:0] r_poff;
    logic [31:0]   r_pdata;
    logic          r_ov;
    t_rsp          r_rsp;

    logic [29:0]   w_wa;
    logic [TW-1:0] w_tag;
    logic [SW-1:0] w_set;
    logic [OW-1:0] w_off;
    assign w_wa  = i_req.data.address[31:2];
    assign w_off = w_wa[OW-1:0];
    assign w_set = w_wa[OW +: SW];
    assign w_tag = w_wa[29 -: TW];

    // hit / victim search over the registered set
    logic          w_hit, w_inv_f;
    logic [WW-1:0] w_hway, w_inv, w_old;
    logic [AW-1:0] w_best;
    t_meta         w_aged [WAYS];
    always_comb begin
        w_hit = 1'b0; w_hway = '0; w_inv_f = 1'b0; w_inv = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_meta_q[w].valid && r_meta_q[w].tag == r_tag) begin
                w_hit = 1'b1; w_hway = WW'(w);
            end
            if (!r_meta_q[w].valid) begin
                w_inv_f = 1'b1; w_inv = WW'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            w_aged[w] = r_meta_q[w];
            if (r_meta_q[w].age != AW'(AGE_MAX)) w_aged[w].age = r_meta_q[w].age + 1'b1;
        end
        w_best = '0; w_old = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (w_aged[w].age >= w_best) begin
                w_best = w_aged[w].age; w_old = WW'(w);
            end
        end
    end

    logic          w_out_free;
    logic          w_rsp_load;
    logic [WW-1:0] w_vic;
    assign w_out_free  = !r_ov || o_rsp.ready;
    assign w_rsp_load  = (r_state == S_LOOK && r_busy) || (r_state == S_WORD) ||
                         ((r_state inside {S_WBLAST, S_OUT}) && w_out_free);
    assign w_vic       = w_inv_f ? w_inv : w_old;
    assign i_req.ready = (r_state == S_IDLE) && !r_ov;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;

    function automatic logic [31:0] f_addr(logic [TW-1:0] t, logic [SW-1:0] s,
                                           logic [OW-1:0] k);
        return {t, s, k, 2'b00};
    endfunction

    // line memory: one port, registered read
    logic          w_lwe;
    logic [LW-1:0] w_la;
    logic [31:0]   w_ld;
    always_comb begin
        w_lwe = 1'b0; w_la = {r_set, r_way, r_k}; w_ld = r_wdata;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && !r_ov && i_req.data.cmd == CMD_FILL && r_busy) begin
                    w_lwe = 1'b1; w_la = {r_fset, r_fway, r_fidx};
                    w_ld  = i_req.data.fill_data;
                end
            end
            S_LOOK:  w_la = {r_set, w_hway, r_off};
            S_WORD: begin
                if (r_cmd == CMD_WRITE) begin
                    w_lwe = 1'b1; w_la = {r_set, r_way, r_off};
                end
            end
            S_MERGE: begin
                w_lwe = 1'b1; w_la = {r_fset, r_fway, r_poff}; w_ld = r_pdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) r_line_mem[w_la] <= w_ld;
        r_word_q <= r_line_mem[w_la];
    end

    // metadata memory: one set a cycle
    logic          w_mwe;
    logic [SW-1:0] w_ms;
    t_meta         w_md [WAYS];
    always_comb begin
        w_mwe = 1'b0; w_ms = r_set;
        for (int w = 0; w < WAYS; w++) w_md[w] = r_meta_q[w];
        case (r_state)
            S_CLEAR: begin
                w_mwe = 1'b1; w_ms = r_clr;
                for (int w = 0; w < WAYS; w++) w_md[w] = '0;
            end
            // a fill word reads the fill set so a merge can update its dirty bit
            S_IDLE: w_ms = (i_req.data.cmd == CMD_FILL) ? r_fset : w_set;
            S_LOOK: begin
                if (r_busy) begin
                    w_mwe = 1'b0;
                end else if (w_hit && r_cmd == CMD_WRITE) begin
                    w_mwe = 1'b1; w_md[w_hway].dirty = 1'b1;
                end else if (!w_hit) begin
                    w_mwe = 1'b1;
                    for (int w = 0; w < WAYS; w++) w_md[w] = w_aged[w];
                    w_md[w_vic] = '{valid: 1'b1, dirty: 1'b0, age: '0, tag: r_tag};
                end
            end
            S_MERGE: begin
                w_mwe = 1'b1; w_ms = r_fset; w_md[r_fway].dirty = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            for (int w = 0; w < WAYS; w++) r_meta_mem[w_ms][w] <= w_md[w];
        end
        for (int w = 0; w < WAYS; w++) r_meta_q[w] <= r_meta_mem[w_ms][w];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_busy  <= 1'b0;
            r_fidx  <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (w_rsp_load) r_ov <= 1'b1;
            else if (r_ov && o_rsp.ready) r_ov <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SW'(SETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid && !r_ov) begin
                        r_cmd   <= i_req.data.cmd;
                        r_tag   <= w_tag;
                        r_set   <= w_set;
                        r_off   <= w_off;
                        r_wdata <= i_req.data.write_data;
                        if (i_req.data.cmd == CMD_FILL) begin
                            if (r_busy) begin
                                if (r_fidx == OW'(LINE_WORDS - 1)) begin
                                    r_fidx <= '0;
                                    if (r_pend) r_state <= S_MERGE;
                                    else r_busy <= 1'b0;
                                end else begin
                                    r_fidx <= r_fidx + 1'b1;
                                end
                            end
                        end else if (i_req.data.cmd != CMD_NONE) begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    if (r_busy) begin
                        r_rsp   <= '{hit: 1'b0, read_data: ALL_ONES, mem_write_valid: 1'b0,
                                     mem_address: '0, mem_write_data: '0,
                                     fill_request: 1'b0, last: 1'b1};
                        r_state <= S_IDLE;
                    end else if (w_hit) begin
                        r_way   <= w_hway;
                        r_state <= S_WORD;
                    end else begin
                        r_way  <= w_vic;
                        r_vtag <= r_meta_q[w_vic].tag;
                        r_k    <= '0;
                        r_busy <= 1'b1;
                        r_fset <= r_set;
                        r_fway <= w_vic;
                        r_fidx <= '0;
                        r_pend <= (r_cmd == CMD_WRITE);
                        r_poff <= r_off;
                        r_pdata <= r_wdata;
                        r_state <= (!w_inv_f && r_meta_q[w_vic].dirty) ? S_WB : S_OUT;
                    end
                end
                S_WORD: begin
                    r_rsp <= '{hit: 1'b1,
                               read_data: (r_cmd == CMD_READ) ? r_word_q : 32'd0,
                               mem_write_valid: 1'b0, mem_address: '0,
                               mem_write_data: '0, fill_request: 1'b0, last: 1'b1};
                    r_state <= S_IDLE;
                end
                S_WB: begin
                    // word k is being read; next cycle it is in r_word_q
                    r_state <= S_WBLAST;
                end
                S_WBLAST: begin
                    if (w_out_free) begin
                        r_rsp <= '{hit: 1'b0, read_data: ALL_ONES, mem_write_valid: 1'b1,
                                   mem_address: f_addr(r_vtag, r_set, r_k),
                                   mem_write_data: r_word_q, fill_request: 1'b0,
                                   last: 1'b0};
                        r_k  <= r_k + 1'b1;
                        r_state <= (r_k == OW'(LINE_WORDS - 1)) ? S_OUT : S_WB;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_rsp <= '{hit: 1'b0, read_data: ALL_ONES, mem_write_valid: 1'b0,
                                   mem_address: f_addr(r_tag, r_set, '0),
                                   mem_write_data: '0, fill_request: 1'b1, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_MERGE: begin
                    r_pend  <= 1'b0;
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/sawbdc_checker.sv
// ----------------------------------------------------------------------------
// sawbdc_checker
// Port-level checks for the write-back cache, bound to the top level.
// ----------------------------------------------------------------------------
module sawbdc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_ready,
    input logic                o_rsp_valid,
    input logic                o_rsp_ready,
    input sawbdc_pkg::t_rsp    o_rsp_data
);
    import sawbdc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_data))
        else $error("stalled result changed");

    a_hit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_data.hit |-> o_rsp_data.last && !o_rsp_data.mem_write_valid)
        else $error("hit result not single");

    a_wb_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_data.mem_write_valid
            |-> !o_rsp_data.last && o_rsp_data.read_data == ALL_ONES)
        else $error("writeback result malformed");

    a_fill_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_data.fill_request |-> o_rsp_data.last && !o_rsp_data.hit)
        else $error("fill request not final");

    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !i_req_ready)
        else $error("item taken while result waits");
endmodule

bind set_assoc_write_back_data_cache sawbdc_checker u_sawbdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .o_rsp_valid (o_rsp.valid),
    .o_rsp_ready (o_rsp.ready),
    .o_rsp_data  (o_rsp.data)
);

>>> tb/set_assoc_write_back_data_cache_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_write_back_data_cache_checker
// Watches the request and response channels, models the cache state and
// compares every response item against the predicted one.
// ----------------------------------------------------------------------------
module set_assoc_write_back_data_cache_checker
    import sawbdc_pkg::*;
#(
    parameter int SETS       = 256,
    parameter int WAYS       = 8,
    parameter int LINE_WORDS = 8,
    parameter int AGE_MAX    = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_req        i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  t_rsp        i_rsp_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int NLINES = SETS * WAYS;

    logic [31:0] line_tag   [NLINES];
    logic        line_valid [NLINES];
    logic        line_dirty [NLINES];
    logic [2:0]  line_age   [NLINES];
    logic [31:0] words      [NLINES * LINE_WORDS];
    int          fill_word;
    int          fill_line;
    logic        filling;
    logic        merge_valid;
    int          merge_offset;
    logic [31:0] merge_data;

    t_rsp expected_rsp[$];
    int   errors;

    assign o_errors  = errors;
    assign o_pending = expected_rsp.size();

    function automatic t_rsp make_rsp(logic hit, logic [31:0] rd, logic mwv,
                                      logic [31:0] maddr, logic [31:0] mdata,
                                      logic freq, logic lst);
        t_rsp r;
        r.hit = hit;
        r.read_data = rd;
        r.mem_write_valid = mwv;
        r.mem_address = maddr;
        r.mem_write_data = mdata;
        r.fill_request = freq;
        r.last = lst;
        return r;
    endfunction

    function automatic logic [31:0] byte_addr(logic [31:0] tag, int set, int word);
        return ((tag * SETS + set) * LINE_WORDS + word) * 4;
    endfunction

    task automatic cache_access(t_req req);
        logic [31:0] waddr;
        int          offset, set, base, victim, e, best;
        logic [31:0] tag;
        begin
            waddr = req.address >> 2;
            offset = waddr % LINE_WORDS;
            set = (waddr / LINE_WORDS) % SETS;
            tag = waddr / LINE_WORDS / SETS;
            base = set * WAYS;
            if (req.cmd == CMD_FILL) begin
                if (filling) begin
                    words[fill_line * LINE_WORDS + fill_word] = req.fill_data;
                    fill_word++;
                    if (fill_word >= LINE_WORDS) begin
                        if (merge_valid) begin
                            words[fill_line * LINE_WORDS + merge_offset] = merge_data;
                            line_dirty[fill_line] = 1'b1;
                        end
                        merge_valid = 1'b0;
                        filling = 1'b0;
                        fill_word = 0;
                    end
                end
                return;
            end
            if (req.cmd == CMD_NONE) return;
            if (filling) begin
                expected_rsp.push_back(make_rsp(0, ALL_ONES, 0, 0, 0, 0, 1));
                return;
            end
            for (int w = 0; w < WAYS; w++) begin
                e = base + w;
                if (line_valid[e] && line_tag[e] == tag) begin
                    if (req.cmd == CMD_READ) begin
                        expected_rsp.push_back(make_rsp(1, words[e * LINE_WORDS + offset],
                                                        0, 0, 0, 0, 1));
                    end else begin
                        words[e * LINE_WORDS + offset] = req.write_data;
                        line_dirty[e] = 1'b1;
                        expected_rsp.push_back(make_rsp(1, 0, 0, 0, 0, 0, 1));
                    end
                    return;
                end
            end
            victim = -1;
            for (int w = 0; w < WAYS; w++) begin
                if (victim < 0 && !line_valid[base + w]) victim = w;
            end
            for (int w = 0; w < WAYS; w++) begin
                if (w != victim && line_age[base + w] < AGE_MAX)
                    line_age[base + w] = 3'(line_age[base + w] + 1);
            end
            if (victim < 0) begin
                best = 0;
                victim = 0;
                for (int w = 0; w < WAYS; w++) begin
                    if (line_age[base + w] >= best) begin
                        best = line_age[base + w];
                        victim = w;
                    end
                end
                e = base + victim;
                if (line_dirty[e]) begin
                    for (int k = 0; k < LINE_WORDS; k++)
                        expected_rsp.push_back(make_rsp(0, ALL_ONES, 1,
                            byte_addr(line_tag[e], set, k), words[e * LINE_WORDS + k],
                            0, 0));
                end
            end
            e = base + victim;
            line_valid[e] = 1'b1;
            line_tag[e] = tag;
            line_age[e] = '0;
            line_dirty[e] = 1'b0;
            fill_line = e;
            fill_word = 0;
            filling = 1'b1;
            merge_valid = (req.cmd == CMD_WRITE);
            merge_offset = offset;
            merge_data = req.write_data;
            expected_rsp.push_back(make_rsp(0, ALL_ONES, 0, byte_addr(tag, set, 0),
                                            0, 1, 1));
        end
    endtask

    initial begin
        errors = 0;
        filling = 1'b0;
        merge_valid = 1'b0;
        fill_word = 0;
        fill_line = 0;
        for (int i = 0; i < NLINES; i++) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_age[i] = '0;
            line_tag[i] = '0;
        end
        for (int i = 0; i < NLINES * LINE_WORDS; i++) words[i] = '0;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && i_req_valid && i_req_ready) cache_access(i_req_data);
        if (i_rst_n && i_rsp_valid && i_rsp_ready) begin
            if (expected_rsp.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response item %p", i_rsp_data);
            end else begin
                want = expected_rsp.pop_front();
                if (want !== i_rsp_data) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p actual %p", want, i_rsp_data);
                end
            end
        end
    end

endmodule

>>> tb/set_assoc_write_back_data_cache_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_write_back_data_cache_test
// Drives reads, writes, fill words and unused commands with random idling on
// both channels; a checker beside the cache predicts and compares each reply.
// ----------------------------------------------------------------------------
module set_assoc_write_back_data_cache_test;
    import sawbdc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    int   sender_idle;
    int   receiver_idle;
    logic hold_off;
    logic hold_go;
    int   errors;
    int   pending;
    int   cycles;

    sawbdc_if #(.T(t_req)) req_ch ();
    sawbdc_if #(.T(t_rsp)) rsp_ch ();

    set_assoc_write_back_data_cache dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    set_assoc_write_back_data_cache_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req_data  (req_ch.data),
        .i_rsp_valid (rsp_ch.valid),
        .i_rsp_ready (rsp_ch.ready),
        .i_rsp_data  (rsp_ch.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("set_assoc_write_back_data_cache_test: FAIL");
                $finish;
            end
        end
    end

    // receiver side, with one long hold-off while requests keep coming
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) rsp_ch.ready <= 1'b0;
            else rsp_ch.ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    logic [31:0] tags[4];

    // valid stays up between back-to-back items and drops only while idling
    task automatic send(logic [1:0] cmd, logic [31:0] addr, logic [31:0] wd,
                        logic [31:0] fd);
        t_req r;
        begin
            while ($urandom_range(99) < sender_idle) begin
                req_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
            r.cmd = cmd;
            r.address = addr;
            r.write_data = wd;
            r.fill_data = fd;
            req_ch.data <= r;
            req_ch.valid <= 1'b1;
            do @(posedge i_clk); while (!req_ch.ready);
            @(negedge i_clk);
        end
    endtask

    // an access; on a likely miss the fill words follow
    task automatic access_and_fill(logic [1:0] cmd, logic [31:0] addr, int nfill);
        begin
            send(cmd, addr, $urandom, $urandom);
            for (int k = 0; k < nfill; k++) send(CMD_FILL, $urandom, $urandom, $urandom);
        end
    endtask

    function automatic logic [31:0] pick_addr(int nsets);
        logic [31:0] a;
        a = {tags[$urandom_range(3)][18:0], 8'd0, 3'($urandom_range(7)), 2'd0};
        a[12:5] = 8'($urandom_range(nsets - 1));
        a[1:0] = 2'($urandom_range(3));
        return a;
    endfunction

    initial begin
        t_req idle_req;
        int   phase_items;
        idle_req = '0;
        hold_go = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = idle_req;
        sender_idle = 0;
        receiver_idle = 0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        tags[0] = 32'h0; tags[1] = 32'h7ffff; tags[2] = 32'h2aaaa; tags[3] = 32'h55555;

        // directed: fill without miss, unused cmd, miss, refusal, hits, extremes
        send(CMD_FILL, 0, 0, 32'hffffffff);
        send(CMD_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send(CMD_WRITE, 32'hffffffff, 32'hffffffff, 0);
        send(CMD_READ, 32'hfffffffc, 0, 0);
        send(CMD_FILL, 0, 0, 32'h0);
        send(CMD_WRITE, 32'h4, 32'h12345678, 0);
        for (int k = 0; k < 7; k++) send(CMD_FILL, 0, 0, 32'hffffffff);
        send(CMD_READ, 32'hfffffffc, 0, 0);
        send(CMD_READ, 32'hffffffe3, 0, 0);
        send(CMD_WRITE, 32'hffffffe0, 32'ha5a5a5a5, 0);
        for (int k = 0; k < 8; k++) access_and_fill(CMD_WRITE, 32'h0, 0);

        // random: three idling phases; most traffic well-formed on few sets
        for (int ph = 0; ph < 3; ph++) begin
            sender_idle = (ph == 0) ? 22 : (ph == 1) ? 71 : 0;
            receiver_idle = (ph == 0) ? 71 : (ph == 1) ? 22 : 0;
            if (ph == 2) hold_go = 1'b1;
            phase_items = 0;
            while (phase_items < 8) begin
                logic [31:0] a;
                logic [1:0]  c;
                a = pick_addr(($urandom_range(9) == 0) ? 256 : 2);
                if ($urandom_range(9) == 0) a[31:13] = 19'($urandom);
                c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
                case ($urandom_range(19))
                    0: send(CMD_NONE, $urandom, $urandom, $urandom);
                    1: send(CMD_FILL, $urandom, $urandom, $urandom);
                    default: send(c, a, $urandom, $urandom);
                endcase
                phase_items++;
                // fill words finish any outstanding fill; extra access may be refused
                if ($urandom_range(7) == 0) send(c, pick_addr(2), $urandom, $urandom);
                for (int k = 0; k < 8; k++)
                    send(CMD_FILL, $urandom, $urandom, $urandom);
            end
        end
        req_ch.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("set_assoc_write_back_data_cache_test: PASS");
        end else begin
            $display("set_assoc_write_back_data_cache_test: FAIL");
        end
        $finish;
    end

endmodule
